[rtl/core/hsl_to_rgba_converter_unit_assert.svh]
// Assertion macros shared by the HSL to RGBA checker.
`ifndef HSL_TO_RGBA_CONVERTER_UNIT_ASSERT_SVH
`define HSL_TO_RGBA_CONVERTER_UNIT_ASSERT_SVH

// Clocked property, ignored while in reset.
`define H2R_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Signal holds its value in the cycle after the condition.
`define H2R_ASSERT_HOLD(lbl, cond, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> $stable(sig)) \
    else $error(msg);

`endif

[rtl/core/hsl2rgba_pkg.sv]
// Constants, types and helpers for the HSL to RGBA converter.
package hsl2rgba_pkg;

  localparam int FRAC_BITS = 16;
  localparam int HUE_W     = 16;
  localparam int FIELD_W   = 17;

  localparam int ONE_W = FRAC_BITS + 1;
  localparam int IN_W  = (ONE_W > FIELD_W) ? ONE_W : FIELD_W;
  localparam int HX_W  = (FRAC_BITS > HUE_W) ? FRAC_BITS : HUE_W;
  localparam int H6_W  = FRAC_BITS + 3;
  localparam int SR_W  = 2 * FRAC_BITS + 2;
  localparam int HI_W  = FRAC_BITS + 2;
  localparam int PA_W  = 2 * FRAC_BITS + 2;
  localparam int PB_W  = 2 * FRAC_BITS + 1;
  localparam int SUM_W = 2 * FRAC_BITS + 3;
  localparam int V_W   = FRAC_BITS + 3;

  typedef logic [ONE_W-1:0] unit_t;

  localparam unit_t ONE  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam unit_t HALF = ONE >> 1;

  localparam logic [H6_W-1:0] H_ONE2 = H6_W'(2) << FRAC_BITS;
  localparam logic [H6_W-1:0] H_ONE4 = H6_W'(4) << FRAC_BITS;
  localparam logic [H6_W-1:0] H_ONE6 = H6_W'(6) << FRAC_BITS;

  // stage load enables shared by the three color lanes
  typedef struct packed {
    logic en2;
    logic en3;
    logic en4;
  } stage_en_t;

  function automatic unit_t clamp_in(logic [FIELD_W-1:0] x);
    logic [IN_W-1:0] xe;
    xe = IN_W'(x);
    return (xe < IN_W'(ONE)) ? ONE_W'(xe) : ONE;
  endfunction

  function automatic unit_t clamp_ramp(logic [H6_W-1:0] x);
    return (x < H6_W'(ONE)) ? ONE_W'(x) : ONE;
  endfunction

endpackage

[rtl/core/hsl2rgba_in_if.sv]
// Input word channel: HSL pixel with alpha.
interface hsl2rgba_in_if import hsl2rgba_pkg::*;;
  logic               valid;
  logic               ready;
  logic [HUE_W-1:0]   hue_turn;
  logic [FIELD_W-1:0] sat_level;
  logic [FIELD_W-1:0] light_level;
  logic [FIELD_W-1:0] alpha_level;

  modport source (output valid, hue_turn, sat_level, light_level, alpha_level, input ready);
  modport sink   (input valid, hue_turn, sat_level, light_level, alpha_level, output ready);
endinterface

[rtl/core/hsl2rgba_out_if.sv]
// Output word channel: RGBA pixel.
interface hsl2rgba_out_if import hsl2rgba_pkg::*;;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] red_level;
  logic [FIELD_W-1:0] green_level;
  logic [FIELD_W-1:0] blue_level;
  logic [FIELD_W-1:0] alpha_out;

  modport source (output valid, red_level, green_level, blue_level, alpha_out, input ready);
  modport sink   (input valid, red_level, green_level, blue_level, alpha_out, output ready);
endinterface

[rtl/core/hsl2rgba_channel.sv]
// One color lane: saturation blend, lightness scale, clamp (stages 2 to 4).
module hsl2rgba_channel import hsl2rgba_pkg::*; (
  input  logic               clk,
  input  stage_en_t          en,
  input  unit_t              ramp,
  input  unit_t              sat,
  input  unit_t              mul,
  input  unit_t              offset,
  output logic [FIELD_W-1:0] level
);

  logic [SR_W-1:0]      sr2;
  logic [HI_W-1:0]      hi_next;
  logic [HI_W-1:0]      hi;
  logic [FRAC_BITS-1:0] lo;
  logic [PA_W-1:0]      pa_next;
  logic [PB_W-1:0]      pb_next;
  logic [PA_W-1:0]      pa;
  logic [PB_W-1:0]      pb;
  logic [SUM_W-1:0]     sum;
  logic [V_W-1:0]       v;
  unit_t                vc;

  // blend = 2*s*r + (1-s); the (1-s) part lands in the integer half only
  assign sr2     = (SR_W'(sat) * SR_W'(ramp)) << 1;
  assign hi_next = HI_W'(sr2 >> FRAC_BITS) + HI_W'(ONE) - HI_W'(sat);

  always_ff @(posedge clk) begin
    if (en.en2) begin
      hi <= hi_next;
      lo <= sr2[FRAC_BITS-1:0];
    end
  end

  assign pa_next = PA_W'(mul) * PA_W'(hi);
  assign pb_next = PB_W'(mul) * PB_W'(lo);

  always_ff @(posedge clk) begin
    if (en.en3) begin
      pa <= pa_next;
      pb <= pb_next;
    end
  end

  assign sum = SUM_W'(pa) + SUM_W'(pb >> FRAC_BITS);
  assign v   = V_W'(sum >> FRAC_BITS) + V_W'(offset);
  assign vc  = (v < V_W'(ONE)) ? ONE_W'(v) : ONE;

  always_ff @(posedge clk) begin
    if (en.en4) begin
      level <= FIELD_W'(vc);
    end
  end

endmodule

[rtl/core/hsl_to_rgba_converter_unit.sv]
// HSL to RGBA converter top level: hue ramps, then three pipelined color lanes.
//
//   channel   dir   word                                    handshake
//   pix_in    in    hue_turn, sat_level, light_level, alpha valid/ready
//   pix_out   out   red, green, blue levels, alpha_out      valid/ready
//
// Four register stages: hue ramps and lightness select, saturation multiply,
// lightness multiply, sum and clamp. One word per cycle while the output is not stalled.
// Each stage loads when it is empty or the stage after it moves, so a stalled
// output only holds words back as far as the first empty stage.
// Synchronous reset clears the valid bits; data registers are not reset.
module hsl_to_rgba_converter_unit import hsl2rgba_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  hsl2rgba_in_if.sink    pix_in,
  hsl2rgba_out_if.source pix_out
);

  logic [HX_W-1:0]      hue_x;
  logic [FRAC_BITS-1:0] h;
  logic [H6_W-1:0]      h6;
  logic [H6_W-1:0]      rr_raw, rg_raw, rb_raw;
  unit_t                s_in, l_in, m_in, off_in;
  logic                 dark;

  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;
  stage_en_t en;

  unit_t rr1, rg1, rb1, s1, m1, off1;
  unit_t m2, off2, off3;
  logic [FIELD_W-1:0] a1, a2, a3, a4;
  logic [FIELD_W-1:0] red_q, green_q, blue_q;

  // hue bits above the fraction are dropped
  assign hue_x = HX_W'(pix_in.hue_turn);
  assign h     = hue_x[FRAC_BITS-1:0];
  assign h6    = (H6_W'(h) << 2) + (H6_W'(h) << 1);

  always_comb begin
    rr_raw = '0;
    rg_raw = '0;
    rb_raw = '0;
    if (h6 < H_ONE2) begin
      rr_raw = H_ONE2 - h6;
      rg_raw = h6;
    end else if (h6 < H_ONE4) begin
      rg_raw = H_ONE4 - h6;
      rb_raw = h6 - H_ONE2;
    end else begin
      rr_raw = h6 - H_ONE4;
      rb_raw = H_ONE6 - h6;
    end
  end

  assign s_in   = clamp_in(pix_in.sat_level);
  assign l_in   = clamp_in(pix_in.light_level);
  assign dark   = l_in < HALF;
  assign m_in   = dark ? l_in : ONE - l_in;
  assign off_in = dark ? '0 : ONE_W'(((ONE_W+1)'(l_in) << 1) - (ONE_W+1)'(ONE));

  assign rdy4 = !v4 || pix_out.ready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign pix_in.ready = rdy1;

  assign en.en2 = rdy2;
  assign en.en3 = rdy3;
  assign en.en4 = rdy4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= pix_in.valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      rr1  <= clamp_ramp(rr_raw);
      rg1  <= clamp_ramp(rg_raw);
      rb1  <= clamp_ramp(rb_raw);
      s1   <= s_in;
      m1   <= m_in;
      off1 <= off_in;
      a1   <= pix_in.alpha_level;
    end
    if (rdy2) begin
      m2   <= m1;
      off2 <= off1;
      a2   <= a1;
    end
    if (rdy3) begin
      off3 <= off2;
      a3   <= a2;
    end
    if (rdy4) begin
      a4   <= a3;
    end
  end

  hsl2rgba_channel u_red (
    .clk(clk), .en(en), .ramp(rr1), .sat(s1), .mul(m2), .offset(off3), .level(red_q)
  );

  hsl2rgba_channel u_green (
    .clk(clk), .en(en), .ramp(rg1), .sat(s1), .mul(m2), .offset(off3), .level(green_q)
  );

  hsl2rgba_channel u_blue (
    .clk(clk), .en(en), .ramp(rb1), .sat(s1), .mul(m2), .offset(off3), .level(blue_q)
  );

  assign pix_out.valid       = v4;
  assign pix_out.red_level   = red_q;
  assign pix_out.green_level = green_q;
  assign pix_out.blue_level  = blue_q;
  assign pix_out.alpha_out   = a4;

endmodule

[rtl/core/hsl2rgba_checker.sv]
// Port-level checks for the HSL to RGBA converter, bound to the top level.
`include "hsl_to_rgba_converter_unit_assert.svh"

module hsl2rgba_checker import hsl2rgba_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic [FIELD_W-1:0] in_alpha,
  input logic               out_valid,
  input logic               out_ready,
  input logic [FIELD_W-1:0] out_red,
  input logic [FIELD_W-1:0] out_green,
  input logic [FIELD_W-1:0] out_blue,
  input logic [FIELD_W-1:0] out_alpha
);

  // input only backs up when every stage is full and the output is blocked
  `H2R_ASSERT(a_in_stall_cause, !in_ready |-> out_valid && !out_ready, "input stalled without output back-pressure")

  `H2R_ASSERT_HOLD(a_out_hold, out_valid && !out_ready, {out_valid, out_red, out_green, out_blue, out_alpha}, "stalled output word changed")

  // with the output open, each word taken in comes out valid with its alpha unchanged
  `H2R_ASSERT(a_latency, $past(in_valid && in_ready, 4) && $past(!rst, 4) && $past(!rst, 3) && $past(!rst, 2) && $past(!rst, 1) && $past(out_ready, 3) && $past(out_ready, 2) && $past(out_ready, 1) |-> out_valid && out_alpha == $past(in_alpha, 4), "word not delivered after four cycles")

endmodule

bind hsl_to_rgba_converter_unit hsl2rgba_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pix_in.valid),
  .in_ready  (pix_in.ready),
  .in_alpha  (pix_in.alpha_level),
  .out_valid (pix_out.valid),
  .out_ready (pix_out.ready),
  .out_red   (pix_out.red_level),
  .out_green (pix_out.green_level),
  .out_blue  (pix_out.blue_level),
  .out_alpha (pix_out.alpha_out)
);

[tb/tb_hsl_to_rgba_converter_unit.sv]
// Testbench for the HSL to RGBA converter: random handshakes, predicted pixels checked in order.
`timescale 1ns / 1ps

module tb_hsl_to_rgba_converter_unit;
  import hsl2rgba_pkg::*;

  localparam int RANDOM_WORDS = 1225;
  localparam int STALL_LIMIT  = 2000;
  localparam int MAX_GAP      = 13;
  localparam int DRAIN_CYCLES = 16;
  localparam logic [FIELD_W-1:0] FIELD_MAX = {FIELD_W{1'b1}};
  localparam logic [FIELD_W-1:0] HALF_LOW  = HALF - unit_t'(1);

  typedef struct packed {
    logic [HUE_W-1:0]   hue;
    logic [FIELD_W-1:0] sat;
    logic [FIELD_W-1:0] light;
    logic [FIELD_W-1:0] alpha;
  } hsl_word_t;

  typedef struct packed {
    logic [FIELD_W-1:0] red;
    logic [FIELD_W-1:0] green;
    logic [FIELD_W-1:0] blue;
    logic [FIELD_W-1:0] alpha;
  } rgba_word_t;

  class rgba_checker;
    rgba_word_t pending_rgba[$];
    int         errors;

    function bit [63:0] to_unit(bit [63:0] v);
      return (v < 64'(ONE)) ? v : 64'(ONE);
    endfunction

    // one color lane: saturation blend, then scale toward black or white
    function logic [FIELD_W-1:0] lane_level(bit [63:0] ramp, bit [63:0] s, bit [63:0] l);
      bit [63:0] one, blend, hi, lo, k, v;
      one   = 64'(ONE);
      blend = 64'd2 * s * ramp + (one - s) * one;
      hi    = blend >> FRAC_BITS;
      lo    = blend & (one - 64'd1);
      if (64'd2 * l < one) begin
        v = (l * hi + ((l * lo) >> FRAC_BITS)) >> FRAC_BITS;
      end else begin
        k = one - l;
        v = ((k * hi + ((k * lo) >> FRAC_BITS)) >> FRAC_BITS) + (64'd2 * l - one);
      end
      return FIELD_W'(to_unit(v));
    endfunction

    function rgba_word_t hsl_to_rgba(hsl_word_t p);
      bit [63:0] one, h, s, l, h6, rr, rg, rb;
      rgba_word_t q;
      one = 64'(ONE);
      h   = 64'(p.hue) & (one - 64'd1);
      s   = to_unit(64'(p.sat));
      l   = to_unit(64'(p.light));
      h6  = 64'd6 * h;
      if (64'd3 * h < one) begin
        rr = 64'd2 * one - h6;
        rg = h6;
        rb = 0;
      end else if (64'd3 * h < 64'd2 * one) begin
        rr = 0;
        rg = 64'd4 * one - h6;
        rb = h6 - 64'd2 * one;
      end else begin
        rr = h6 - 64'd4 * one;
        rg = 0;
        rb = 64'd6 * one - h6;
      end
      q.red   = lane_level(to_unit(rr), s, l);
      q.green = lane_level(to_unit(rg), s, l);
      q.blue  = lane_level(to_unit(rb), s, l);
      q.alpha = p.alpha;
      return q;
    endfunction

    function void note_pixel(hsl_word_t p);
      pending_rgba.push_back(hsl_to_rgba(p));
    endfunction

    function void report(string what, logic [FIELD_W-1:0] exp_v, logic [FIELD_W-1:0] act_v);
      errors++;
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, what, exp_v, act_v);
    endfunction

    function void check_rgba(rgba_word_t act);
      rgba_word_t exp_w;
      if (pending_rgba.size() == 0) begin
        errors++;
        $display("%0t unexpected word: expected none, actual %h", $time, act);
        return;
      end
      exp_w = pending_rgba.pop_front();
      if (act.red   !== exp_w.red)   report("red_level",   exp_w.red,   act.red);
      if (act.green !== exp_w.green) report("green_level", exp_w.green, act.green);
      if (act.blue  !== exp_w.blue)  report("blue_level",  exp_w.blue,  act.blue);
      if (act.alpha !== exp_w.alpha) report("alpha_out",   exp_w.alpha, act.alpha);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  hsl2rgba_in_if  pix_in();
  hsl2rgba_out_if pix_out();

  hsl_to_rgba_converter_unit dut (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (pix_in),
    .pix_out (pix_out)
  );

  always #1 clk = ~clk;

  rgba_checker board = new();
  bit src_calm;
  bit snk_calm;
  int stall_cycles;

  function automatic int draw_gap(bit calm);
    return calm ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // occasional stretches where a side never idles
  function automatic bit flip_calm(bit calm);
    return ($urandom_range(0, 99) < 3) ? !calm : calm;
  endfunction

  task automatic send_pixel(input hsl_word_t p);
    int gap;
    src_calm = flip_calm(src_calm);
    gap = draw_gap(src_calm);
    if (gap > 0) begin
      pix_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_in.valid       <= 1'b1;
    pix_in.hue_turn    <= p.hue;
    pix_in.sat_level   <= p.sat;
    pix_in.light_level <= p.light;
    pix_in.alpha_level <= p.alpha;
    do @(posedge clk); while (!pix_in.ready);
    board.note_pixel(p);
  endtask

  // mostly in range, with edges and out-of-range codes mixed in
  function automatic logic [FIELD_W-1:0] draw_level();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 75) return FIELD_W'($urandom_range(0, int'(ONE)));
    if (pick < 80) return '0;
    if (pick < 85) return ONE;
    if (pick < 88) return HALF;
    if (pick < 91) return HALF_LOW;
    return FIELD_W'($urandom_range(0, int'(FIELD_MAX)));
  endfunction

  task automatic run_directed();
    logic [HUE_W-1:0]   hue_marks[10];
    logic [FIELD_W-1:0] sat_marks[3];
    logic [FIELD_W-1:0] light_marks[5];
    hsl_word_t p;
    int n;
    // segment edges: 3h < ONE up to 21845, 3h < 2*ONE up to 43690
    hue_marks   = '{16'd0, 16'd1, 16'd10922, 16'd21845, 16'd21846,
                    16'd32768, 16'd43690, 16'd43691, 16'd54613, 16'hFFFF};
    sat_marks   = '{'0, ONE, FIELD_MAX};
    light_marks = '{'0, HALF_LOW, HALF, ONE, FIELD_MAX};
    n = 0;
    foreach (hue_marks[i]) begin
      p = '{hue: hue_marks[i], sat: ONE, light: HALF,
            alpha: (i % 2) ? FIELD_MAX : '0};
      send_pixel(p);
    end
    foreach (sat_marks[i]) begin
      foreach (light_marks[j]) begin
        n++;
        p = '{hue: HUE_W'($urandom_range(0, 65535)), sat: sat_marks[i],
              light: light_marks[j], alpha: (n % 2) ? FIELD_MAX : '0};
        send_pixel(p);
      end
    end
  endtask

  task automatic run_random();
    hsl_word_t p;
    repeat (RANDOM_WORDS) begin
      p.hue   = HUE_W'($urandom_range(0, 65535));
      p.sat   = draw_level();
      p.light = draw_level();
      p.alpha = FIELD_W'($urandom_range(0, int'(FIELD_MAX)));
      send_pixel(p);
    end
  endtask

  initial begin
    pix_in.valid       <= 1'b0;
    pix_in.hue_turn    <= '0;
    pix_in.sat_level   <= '0;
    pix_in.light_level <= '0;
    pix_in.alpha_level <= '0;
    pix_out.ready      <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    run_random();
    pix_in.valid <= 1'b0;
    while (board.pending_rgba.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // receiver: ready held until a word is taken, then a fresh stall is drawn
  initial begin
    int gap;
    @(negedge rst);
    @(posedge clk);
    forever begin
      snk_calm = flip_calm(snk_calm);
      gap = draw_gap(snk_calm);
      if (gap > 0) begin
        pix_out.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pix_out.ready <= 1'b1;
      do @(posedge clk); while (!pix_out.valid);
    end
  end

  always @(posedge clk) begin
    if (!rst && pix_out.valid && pix_out.ready) begin
      board.check_rgba('{red: pix_out.red_level, green: pix_out.green_level,
                         blue: pix_out.blue_level, alpha: pix_out.alpha_out});
    end
  end

  always @(posedge clk) begin
    if (rst || (pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule
